// ===== rtl/lom_pkg.sv =====
// Shared types and constants of the limit order matcher.
`default_nettype none
package lom_pkg;

    localparam int PRICE_LEVELS_DEF = 16;
    localparam int LEVEL_DEPTH_DEF  = 4;
    localparam int MAX_RESULTS      = 64;

    typedef struct packed {
        logic        is_sell;
        logic [3:0]  price_tick;
        logic [15:0] order_quantity;
        logic [15:0] agent;
    } t_in_word;

    typedef struct packed {
        logic        is_trade;
        logic [15:0] buyer_agent;
        logic [15:0] seller_agent;
        logic [3:0]  fill_price;
        logic [15:0] fill_quantity;
        logic [15:0] rested_quantity;
        logic        status;
        logic        last;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic lvl_rd;
        logic next_lvl;
        logic meta_cap;
        logic fill;
        logic rest_rd;
        logic rest_wr;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic lvl_stop;
        logic qty_zero;
        logic meta_empty;
        logic fill_ok;
        logic fill_stay;
        logic fill_next_lvl;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/lom_ctrl.sv =====
// Sequencer of the limit order matcher.
`default_nettype none
module lom_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire lom_pkg::t_sts i_sts,
    output lom_pkg::t_cmd      o_cmd,
    output logic               o_idle
);
    import lom_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_LVL   = 8'b0000_0100,
        ST_META  = 8'b0000_1000,
        ST_ORD   = 8'b0001_0000,
        ST_REST  = 8'b0010_0000,
        ST_RMETA = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LVL;
                end
            end
            ST_LVL: begin
                if (i_sts.lvl_stop || i_sts.qty_zero) begin
                    n_state = ST_REST;
                end else begin
                    o_cmd.lvl_rd = 1'b1;
                    n_state      = ST_META;
                end
            end
            ST_META: begin
                if (i_sts.meta_empty) begin
                    o_cmd.next_lvl = 1'b1;
                    n_state        = ST_LVL;
                end else begin
                    o_cmd.meta_cap = 1'b1;
                    n_state        = ST_ORD;
                end
            end
            ST_ORD: begin
                if (i_sts.fill_ok) begin
                    o_cmd.fill = 1'b1;
                    if (i_sts.fill_stay) begin
                        n_state = ST_ORD;
                    end else if (i_sts.fill_next_lvl) begin
                        o_cmd.next_lvl = 1'b1;
                        n_state        = ST_LVL;
                    end else begin
                        n_state = ST_REST;
                    end
                end
            end
            ST_REST: begin
                if (i_sts.qty_zero) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.rest_rd = 1'b1;
                    n_state       = ST_RMETA;
                end
            end
            ST_RMETA: begin
                o_cmd.rest_wr = 1'b1;
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lom_dp.sv =====
// Datapath of the limit order matcher: book memories, order registers, result words.
`default_nettype none
module lom_dp #(
    parameter int PRICE_LEVELS = lom_pkg::PRICE_LEVELS_DEF,
    parameter int LEVEL_DEPTH  = lom_pkg::LEVEL_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lom_pkg::t_cmd     i_cmd,
    input  wire lom_pkg::t_in_word i_in_word,
    input  wire logic              i_out_stall,
    output lom_pkg::t_sts          o_sts,
    output lom_pkg::t_out_word     o_out_word,
    output logic                   o_out_valid
);
    import lom_pkg::*;

    localparam int LW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
    localparam int BW = $clog2(2 * PRICE_LEVELS);
    localparam int IW = $clog2(PRICE_LEVELS + 1);
    localparam int HW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW = $clog2(LEVEL_DEPTH + 1);
    localparam int MD = 2 * PRICE_LEVELS;
    localparam int ND = 2 * PRICE_LEVELS * LEVEL_DEPTH;
    localparam int AW = $clog2(ND);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    // level metadata: head slot and occupancy
    logic [HW+CW-1:0] r_meta [MD];
    logic [HW+CW-1:0] r_meta_q;
    // resting orders: agent in the upper half, quantity in the lower
    logic [31:0]      r_ord [ND];
    logic [31:0]      r_ord_q;

    logic [BW-1:0] r_clr;
    logic          r_sell;
    logic [LW-1:0] r_price;
    logic [15:0]   r_qty;
    logic [15:0]   r_agent;
    logic [IW-1:0] r_i;
    logic [NW-1:0] r_n;
    logic [HW-1:0] r_head;
    logic [CW-1:0] r_cnt;
    logic [BW-1:0] r_b;
    t_out_word     r_hold;
    logic          r_hold_vld;
    logic [15:0]   r_rested;
    logic          r_status;
    t_out_word     r_out;
    logic          r_out_vld;

    logic [LW-1:0] w_lvl;
    logic          w_cross_fail;
    logic [BW-1:0] w_b_opp, w_b_own;
    logic [HW-1:0] w_mh;
    logic [CW-1:0] w_mc;
    logic [15:0]   w_rq, w_ra, w_t, w_qty_after;
    logic          w_consumed;
    logic [HW-1:0] w_head_nx;
    logic [CW-1:0] w_cnt_after;
    logic          w_more;
    logic [CW:0]   w_sum;
    logic [HW-1:0] w_slot;
    logic          w_out_free;
    logic [LW-1:0] w_price_in;
    t_out_word     w_fin_word;

    logic             w_meta_we;
    logic [BW-1:0]    w_meta_wa;
    logic [HW+CW-1:0] w_meta_wd;
    logic             w_meta_re;
    logic [BW-1:0]    w_meta_ra;
    logic             w_ord_we;
    logic [AW-1:0]    w_ord_wa;
    logic [31:0]      w_ord_wd;
    logic             w_ord_re;
    logic [AW-1:0]    w_ord_ra;

    assign w_price_in = ({28'd0, i_in_word.price_tick} >= 32'(PRICE_LEVELS))
                        ? LW'(PRICE_LEVELS - 1) : LW'(i_in_word.price_tick);

    assign w_lvl = r_sell ? (LW'(PRICE_LEVELS - 1) - LW'(r_i)) : LW'(r_i);
    assign w_cross_fail = r_sell ? (w_lvl < r_price) : (w_lvl > r_price);
    assign w_b_opp = (r_sell ? BW'(0) : BW'(PRICE_LEVELS)) + BW'(w_lvl);
    assign w_b_own = (r_sell ? BW'(PRICE_LEVELS) : BW'(0)) + BW'(r_price);

    assign w_mh = r_meta_q[HW+CW-1:CW];
    assign w_mc = r_meta_q[CW-1:0];

    assign w_rq        = r_ord_q[15:0];
    assign w_ra        = r_ord_q[31:16];
    assign w_t         = (w_rq < r_qty) ? w_rq : r_qty;
    assign w_qty_after = r_qty - w_t;
    assign w_consumed  = (w_rq == w_t);
    assign w_head_nx   = (r_head == HW'(LEVEL_DEPTH - 1)) ? HW'(0) : r_head + HW'(1);
    assign w_cnt_after = w_consumed ? r_cnt - CW'(1) : r_cnt;
    assign w_more      = (w_qty_after != 16'd0) && ((r_n + NW'(1)) < NW'(MAX_RESULTS));

    assign w_sum  = (CW+1)'(w_mh) + (CW+1)'(w_mc);
    assign w_slot = (w_sum >= (CW+1)'(LEVEL_DEPTH)) ? HW'(w_sum - (CW+1)'(LEVEL_DEPTH))
                                                    : HW'(w_sum);

    assign w_out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        o_sts               = '0;
        o_sts.clr_done      = (r_clr == BW'(MD - 1));
        o_sts.lvl_stop      = (r_i == IW'(PRICE_LEVELS)) || (r_n == NW'(MAX_RESULTS))
                              || w_cross_fail;
        o_sts.qty_zero      = (r_qty == 16'd0);
        o_sts.meta_empty    = (w_mc == CW'(0));
        o_sts.fill_ok       = !r_hold_vld || w_out_free;
        o_sts.fill_stay     = w_more && (w_cnt_after != CW'(0));
        o_sts.fill_next_lvl = w_more && (w_cnt_after == CW'(0));
        o_sts.out_free      = w_out_free;
    end

    // last word of an order: the held fill or a bare word, with rest and status
    always_comb begin
        w_fin_word                 = r_hold_vld ? r_hold : t_out_word'('0);
        w_fin_word.rested_quantity = r_rested;
        w_fin_word.status          = r_status;
        w_fin_word.last            = 1'b1;
    end

    // memory port selection
    always_comb begin
        w_meta_we = 1'b0;
        w_meta_wa = r_b;
        w_meta_wd = '0;
        w_meta_re = 1'b0;
        w_meta_ra = w_b_opp;
        w_ord_we  = 1'b0;
        w_ord_wa  = AW'(r_b) * AW'(LEVEL_DEPTH) + AW'(r_head);
        w_ord_wd  = {w_ra, w_rq - w_t};
        w_ord_re  = 1'b0;
        w_ord_ra  = AW'(r_b) * AW'(LEVEL_DEPTH) + AW'(w_mh);
        if (i_cmd.clr) begin
            w_meta_we = 1'b1;
            w_meta_wa = r_clr;
        end
        if (i_cmd.lvl_rd) begin
            w_meta_re = 1'b1;
        end
        if (i_cmd.rest_rd) begin
            w_meta_re = 1'b1;
            w_meta_ra = w_b_own;
        end
        if (i_cmd.meta_cap) begin
            w_ord_re = 1'b1;
        end
        if (i_cmd.fill) begin
            if (w_consumed) begin
                w_meta_we = 1'b1;
                w_meta_wd = {w_head_nx, w_cnt_after};
                w_ord_re  = 1'b1;
                w_ord_ra  = AW'(r_b) * AW'(LEVEL_DEPTH) + AW'(w_head_nx);
            end else begin
                w_ord_we = 1'b1;
            end
        end
        if (i_cmd.rest_wr && (w_mc < CW'(LEVEL_DEPTH))) begin
            w_meta_we = 1'b1;
            w_meta_wd = {w_mh, w_mc + CW'(1)};
            w_ord_we  = 1'b1;
            w_ord_wa  = AW'(r_b) * AW'(LEVEL_DEPTH) + AW'(w_slot);
            w_ord_wd  = {r_agent, r_qty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_meta_we) r_meta[w_meta_wa] <= w_meta_wd;
        if (w_meta_re) r_meta_q <= r_meta[w_meta_ra];
        if (w_ord_we) r_ord[w_ord_wa] <= w_ord_wd;
        if (w_ord_re) r_ord_q <= r_ord[w_ord_ra];
    end

    // order and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sell   <= i_in_word.is_sell;
            r_price  <= w_price_in;
            r_qty    <= i_in_word.order_quantity;
            r_agent  <= i_in_word.agent;
            r_rested <= 16'd0;
            r_status <= 1'b0;
        end
        if (i_cmd.lvl_rd || i_cmd.rest_rd) begin
            r_b <= w_meta_ra;
        end
        if (i_cmd.meta_cap) begin
            r_head <= w_mh;
            r_cnt  <= w_mc;
        end
        if (i_cmd.fill) begin
            r_qty  <= w_qty_after;
            r_head <= w_consumed ? w_head_nx : r_head;
            r_cnt  <= w_cnt_after;
            r_hold <= '{is_trade: 1'b1,
                        buyer_agent: r_sell ? w_ra : r_agent,
                        seller_agent: r_sell ? r_agent : w_ra,
                        fill_price: 4'(w_lvl),
                        fill_quantity: w_t,
                        rested_quantity: 16'd0,
                        status: 1'b0,
                        last: 1'b0};
        end
        if (i_cmd.rest_wr) begin
            if (w_mc < CW'(LEVEL_DEPTH)) r_rested <= r_qty;
            else                         r_status <= 1'b1;
        end
        if (i_cmd.fill && r_hold_vld) begin
            r_out <= r_hold;
        end else if (i_cmd.fin) begin
            r_out <= w_fin_word;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_i        <= '0;
            r_n        <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr && (r_clr != BW'(MD - 1))) r_clr <= r_clr + BW'(1);
            if (i_cmd.load) begin
                r_i        <= '0;
                r_n        <= '0;
                r_hold_vld <= 1'b0;
            end
            if (i_cmd.next_lvl) r_i <= r_i + IW'(1);
            if (i_cmd.fill) begin
                r_n        <= r_n + NW'(1);
                r_hold_vld <= 1'b1;
            end
            if (i_cmd.fin) r_hold_vld <= 1'b0;
            if ((i_cmd.fill && r_hold_vld) || i_cmd.fin) r_out_vld <= 1'b1;
            else if (!i_out_stall)                       r_out_vld <= 1'b0;
        end
    end

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_vld;

endmodule
`default_nettype wire

// ===== rtl/limit_order_matcher.sv =====
// From acceptance to the last result the order visits the price levels in turn: it reads each
// level's metadata and then fills against its resting orders one at a time, and a remainder is
// then rested on the order's own level if it has room. Output stalls add to the time taken.
// One order at a time; the next word is taken the cycle after the last result is registered.
// After reset a clearing pass empties all levels; no word is accepted during it.
// The output register lets results wait while matching goes on.
`default_nettype none
module limit_order_matcher #(
    parameter int PRICE_LEVELS = lom_pkg::PRICE_LEVELS_DEF,
    parameter int LEVEL_DEPTH  = lom_pkg::LEVEL_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire lom_pkg::t_in_word  i_in_word,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output lom_pkg::t_out_word      o_out_word,
    input  wire logic               i_out_stall
);
    import lom_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_idle;

    lom_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    lom_dp #(
        .PRICE_LEVELS (PRICE_LEVELS),
        .LEVEL_DEPTH  (LEVEL_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid)
    );

    assign o_in_stall = !w_idle;

endmodule
`default_nettype wire

// ===== verif/lom_checker.sv =====
// Checker for the limit order matcher: book model, expected results and comparison.
`timescale 1ns / 100ps
module lom_checker
    import lom_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_in_stall,
    input  wire logic      i_out_valid,
    input  wire t_out_word i_out_word,
    input  wire logic      i_out_stall,
    output int             o_errors,
    output int             o_pending,
    output int             o_orders,
    output int             o_fills
);
    localparam int LEVELS = PRICE_LEVELS_DEF;
    localparam int DEPTH  = LEVEL_DEPTH_DEF;

    logic [15:0] book_qty   [2*LEVELS][DEPTH];
    logic [15:0] book_agent [2*LEVELS][DEPTH];
    int          book_head  [2*LEVELS];
    int          book_count [2*LEVELS];
    t_out_word   fills_due[$];

    assign o_pending = fills_due.size();

    task automatic predict_order(input t_in_word w);
        t_out_word   r;
        logic [15:0] left, take;
        int          limit, lvl, b, slot, n;
        logic [15:0] rested;
        logic        dropped;
        left    = w.order_quantity;
        limit   = w.price_tick;
        n       = 0;
        rested  = '0;
        dropped = 1'b0;
        for (int i = 0; i < LEVELS && left != 0 && n < MAX_RESULTS; i++) begin
            lvl = w.is_sell ? LEVELS - 1 - i : i;
            // bids on side 0, asks on side 1
            b = (w.is_sell ? 0 : LEVELS) + lvl;
            if (w.is_sell ? (lvl < limit) : (lvl > limit)) break;
            while (left != 0 && book_count[b] != 0 && n < MAX_RESULTS) begin
                slot = book_head[b];
                take = book_qty[b][slot] < left ? book_qty[b][slot] : left;
                r = '0;
                r.is_trade      = 1'b1;
                r.buyer_agent   = w.is_sell ? book_agent[b][slot] : w.agent;
                r.seller_agent  = w.is_sell ? w.agent : book_agent[b][slot];
                r.fill_price    = lvl[3:0];
                r.fill_quantity = take;
                fills_due.insert(fills_due.size(), r);
                n++;
                left -= take;
                book_qty[b][slot] -= take;
                if (book_qty[b][slot] == 0) begin
                    book_head[b] = (book_head[b] + 1) % DEPTH;
                    book_count[b]--;
                end
            end
        end
        if (left != 0) begin
            b = (w.is_sell ? LEVELS : 0) + limit;
            if (book_count[b] < DEPTH) begin
                slot = (book_head[b] + book_count[b]) % DEPTH;
                book_qty[b][slot]   = left;
                book_agent[b][slot] = w.agent;
                book_count[b]++;
                rested = left;
            end else begin
                dropped = 1'b1;
            end
        end
        if (n == 0) fills_due.insert(fills_due.size(), t_out_word'('0));
        r = fills_due.pop_back();
        r.rested_quantity = rested;
        r.status          = dropped;
        r.last            = 1'b1;
        fills_due.insert(fills_due.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            o_errors = 0;
            o_orders = 0;
            o_fills  = 0;
            fills_due.delete();
            for (int b = 0; b < 2*LEVELS; b++) begin
                book_head[b]  = 0;
                book_count[b] = 0;
            end
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_order(i_in_word);
                o_orders++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (fills_due.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_out_word);
                    o_errors++;
                end else begin
                    want = fills_due.pop_front();
                    if (i_out_word.is_trade) o_fills++;
                    if (i_out_word !== want) begin
                        $display("%0t: mismatch exp %h got %h", $time, want, i_out_word);
                        $display("  trade %b/%b buy %h/%h sell %h/%h px %h/%h",
                                 want.is_trade, i_out_word.is_trade,
                                 want.buyer_agent, i_out_word.buyer_agent,
                                 want.seller_agent, i_out_word.seller_agent,
                                 want.fill_price, i_out_word.fill_price);
                        $display("  qty %h/%h rest %h/%h st %b/%b last %b/%b",
                                 want.fill_quantity, i_out_word.fill_quantity,
                                 want.rested_quantity, i_out_word.rested_quantity,
                                 want.status, i_out_word.status,
                                 want.last, i_out_word.last);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/tb_top.sv =====
// Stimulus and verdict for the limit order matcher testbench.
`timescale 1ns / 100ps
module tb_top;
    import lom_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall = 1'b0;
    int        errors, pending, orders, fills;
    int        cycles = 0;
    bit        calm = 1'b0;
    bit        hold_off = 1'b0;

    always #5 clk = ~clk;

    limit_order_matcher u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_word  (in_word),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_word (out_word),
        .i_out_stall(out_stall)
    );

    lom_checker u_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_word  (in_word),
        .i_in_stall (in_stall),
        .i_out_valid(out_valid),
        .i_out_word (out_word),
        .i_out_stall(out_stall),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_orders   (orders),
        .o_fills    (fills)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int run;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                run = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (run) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // present one word and hold it until taken
    task automatic send_order(input logic sell, input logic [3:0] px,
                              input logic [15:0] qty, input logic [15:0] who);
        in_word  <= '{is_sell: sell, price_tick: px, order_quantity: qty, agent: who};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // random order biased to the middle of the book so that crosses are common
    task automatic random_order();
        logic [15:0] q;
        logic        s;
        s = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       q = 16'($urandom);
            1:       q = 16'(0);
            2:       q = 16'hffff;
            default: q = 16'($urandom_range(1, 40));
        endcase
        send_order(s, 4'($urandom_range(4, 11)), q, 16'($urandom));
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty book, zero quantity, extremes, full level, sweeps
        send_order(1'b0, 4'd0, 16'd0, 16'h0000);
        send_order(1'b1, 4'd15, 16'd0, 16'hffff);
        for (int k = 0; k < 5; k++) send_order(1'b0, 4'd0, 16'd10 + 16'(k), 16'h1000 + 16'(k));
        for (int k = 0; k < 5; k++) send_order(1'b1, 4'd15, 16'hffff, 16'hf000 + 16'(k));
        send_order(1'b0, 4'd15, 16'hffff, 16'haaaa);
        send_order(1'b1, 4'd0, 16'hffff, 16'h5555);
        send_order(1'b1, 4'd0, 16'h0030, 16'h0f0f);
        send_order(1'b0, 4'd3, 16'd5, 16'h1234);
        send_order(1'b1, 4'd3, 16'd2, 16'h4321);
        send_order(1'b1, 4'd3, 16'd9, 16'h8765);
        send_order(1'b0, 4'd8, 16'd20, 16'h7777);
        go_idle();

        // block fills up behind a long output hold-off
        hold_off = 1'b1;
        for (int k = 0; k < 8; k++) random_order();
        go_idle();

        for (int k = 0; k < 140; k++) random_order();
        go_idle();

        calm = 1'b1;
        for (int k = 0; k < 50; k++) random_order();
        go_idle();
        repeat (100) @(negedge clk);

        $display("%0d orders matched, %0d fills checked, full levels and sweeps included",
                 orders, fills);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
